### sv/lzw_pkg.sv
// Shared constants and types for the LZW byte encoder.
// No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package lzw_pkg;

  localparam int CODE_BITS  = 12;
  localparam int BYTE_BITS  = 8;
  localparam int PAIR_BITS  = CODE_BITS + BYTE_BITS;
  localparam int COUNT_BITS = CODE_BITS + 1;
  localparam int DICT_SIZE  = 1 << CODE_BITS;
  localparam int INDEX_SIZE = 1 << PAIR_BITS;
  localparam int FIRST_FREE = 256;
  localparam int TDATA_BITS = ((CODE_BITS + 7) / 8) * 8;

  // Output queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  typedef logic [CODE_BITS-1:0]  code_t;
  typedef logic [BYTE_BITS-1:0]  byte_t;
  typedef logic [PAIR_BITS-1:0]  pair_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic  final_code;
    code_t code_word;
  } result_t;

endpackage

`default_nettype wire

### sv/lzw_byte_encoder_top.sv
// LZW byte encoder top level: control sequencer, dictionary memories, output queue.
// Depends on lzw_pkg and lzw_ram.
//
// Usage:
//   Input stream (s_*): one message byte per request in s_tdata, s_tlast high on
//   the last byte of a message. Output stream (m_*): one code per request in
//   m_tdata[11:0], m_tlast high on the last code of a message.
//   Each byte takes three steps: accept plus index-table read, code-table read
//   for verification, then the decision with write-back. A byte yields zero, one
//   or two codes; they appear on m_* in the cycle after the decision at the earliest.
//   The index table is addressed by {prefix, byte} and returns a candidate code;
//   the code table holds the pair stored under each code and confirms the match,
//   so stale entries from earlier messages are rejected without any clearing.
//   Codes wait in a four-entry queue; a byte is taken while at least two slots
//   are free, so a stalled receiver holds off input only once three codes pile up.
//   At the end of a message the prefix and next free code return to their start
//   values, which empties the dictionary. Reset does the same and empties the
//   queue; no memory sweep is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module lzw_byte_encoder_top
  import lzw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [BYTE_BITS-1:0]  s_tdata,   // [7:0] data_byte
  input  wire logic                  s_tlast,   // end_of_message
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [TDATA_BITS-1:0] m_tdata,   // [11:0] code_word, rest zero
  output logic                       m_tlast    // final_code
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOK   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  localparam count_t FIRST_FREE_C = count_t'(FIRST_FREE);
  localparam count_t DICT_SIZE_C  = count_t'(DICT_SIZE);

  logic [1:0] state;
  code_t      prefix_code;
  logic       prefix_valid;
  count_t     next_free;
  byte_t      cur_byte;
  logic       cur_last;
  code_t      cand;

  // Output queue
  result_t            queue [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QCNT_BITS-1:0] q_count;

  logic in_accept;
  logic out_accept;

  // Memory ports
  code_t tbl_rdata;
  pair_t dict_rdata;
  logic  mem_we;
  pair_t cur_pair;

  // Decision outputs
  logic   hit;
  logic   emit_miss;
  logic   do_insert;
  code_t  prefix_next;
  logic [1:0] push_n;
  result_t push0;
  result_t push1;

  assign s_tready   = (state == S_IDLE) &&
                      (q_count <= QCNT_BITS'(QUEUE_DEPTH - 2));
  assign in_accept  = s_tvalid && s_tready;
  assign out_accept = m_tvalid && m_tready;
  assign cur_pair   = {prefix_code, cur_byte};

  // Index table: {prefix, byte} -> candidate code
  lzw_ram #(
    .WIDTH (CODE_BITS),
    .DEPTH (INDEX_SIZE)
  ) u_index (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cur_pair),
    .wdata (next_free[CODE_BITS-1:0]),
    .re    (in_accept),
    .raddr ({prefix_code, s_tdata}),
    .rdata (tbl_rdata)
  );

  // Code table: code -> {prefix, byte}
  lzw_ram #(
    .WIDTH (PAIR_BITS),
    .DEPTH (DICT_SIZE)
  ) u_dict (
    .clk   (clk),
    .we    (mem_we),
    .waddr (next_free[CODE_BITS-1:0]),
    .wdata (cur_pair),
    .re    (state == S_LOOK),
    .raddr (tbl_rdata),
    .rdata (dict_rdata)
  );

  // Match check, insert and emit decision
  always_comb begin
    hit = 1'b0;
    if (prefix_valid && (count_t'(cand) >= FIRST_FREE_C) &&
        (count_t'(cand) < next_free) && (dict_rdata == cur_pair)) begin
      hit = 1'b1;
    end
    emit_miss   = 1'b0;
    do_insert   = 1'b0;
    prefix_next = code_t'(cur_byte);
    if (!prefix_valid) begin
      prefix_next = code_t'(cur_byte);
    end else if (hit) begin
      prefix_next = cand;
    end else begin
      emit_miss = 1'b1;
      if (next_free < DICT_SIZE_C) begin
        do_insert = 1'b1;
      end
    end
    mem_we = (state == S_DECIDE) && do_insert;

    push0.code_word  = emit_miss ? prefix_code : prefix_next;
    push0.final_code = !emit_miss;
    push1.code_word  = prefix_next;
    push1.final_code = 1'b1;
    push_n = 2'd0;
    if (state == S_DECIDE) begin
      push_n = 2'(emit_miss) + 2'(cur_last);
    end
  end

  // Sequencer and message state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prefix_code  <= '0;
      prefix_valid <= 1'b0;
      next_free    <= FIRST_FREE_C;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= S_IDLE;
          if (cur_last) begin
            prefix_code  <= '0;
            prefix_valid <= 1'b0;
            next_free    <= FIRST_FREE_C;
          end else begin
            prefix_code  <= prefix_next;
            prefix_valid <= 1'b1;
            if (do_insert) begin
              next_free <= next_free + count_t'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the request and the candidate code
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_byte <= s_tdata;
      cur_last <= s_tlast;
    end
    if (state == S_LOOK) begin
      cand <= tbl_rdata;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + QPTR_BITS'(1)] <= push1;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QPTR_BITS'(push_n);
      rd_ptr  <= rd_ptr + QPTR_BITS'(out_accept);
      q_count <= q_count + QCNT_BITS'(push_n) - QCNT_BITS'(out_accept);
    end
  end

  assign m_tvalid = (q_count != '0);
  assign m_tdata  = TDATA_BITS'(queue[rd_ptr].code_word);
  assign m_tlast  = queue[rd_ptr].final_code;

endmodule

`default_nettype wire

### sv/lzw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for the LZW byte encoder: streams messages of bytes in, predicts
// the emitted codes with a software dictionary and checks every code that leaves.
// Depends on lzw_pkg and lzw_byte_encoder_top.
`timescale 1ns / 1ps

module tb;
  import lzw_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int MAX_GAP      = 17;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;
  localparam int CYCLE_LIMIT  = 1_500_000;

  // Tracks the dictionary the encoder should be building and the codes it owes.
  class lzw_scoreboard;
    code_t       dict_codes[pair_t];
    code_t       prefix;
    bit          have_prefix;
    int unsigned next_code;
    result_t     expected_codes[$];
    int unsigned errors;
    int unsigned codes_checked;
    int unsigned bytes_seen;
    int unsigned messages_seen;
    int unsigned double_results;
    bit          reached_full;

    function new();
      clear_message();
    endfunction

    // End of message: drop the dictionary and the prefix.
    function void clear_message();
      dict_codes.delete();
      prefix      = '0;
      have_prefix = 1'b0;
      next_code   = FIRST_FREE;
    endfunction

    function void push_code(code_t c, bit fin);
      result_t r;
      r.code_word  = c;
      r.final_code = fin;
      expected_codes = {expected_codes, r};
    endfunction

    // Advance the dictionary by one accepted byte and queue the codes it causes.
    function void note_byte(byte_t b, bit last);
      pair_t       key;
      int unsigned n;
      n = 0;
      bytes_seen++;
      if (!have_prefix) begin
        prefix      = code_t'(b);
        have_prefix = 1'b1;
      end else begin
        key = {prefix, b};
        if (dict_codes.exists(key)) begin
          prefix = dict_codes[key];
        end else begin
          push_code(prefix, 1'b0);
          n++;
          // Once every code is taken, keep emitting but stop adding pairs
          if (next_code < DICT_SIZE) begin
            dict_codes[key] = code_t'(next_code);
            next_code++;
          end else begin
            reached_full = 1'b1;
          end
          prefix = code_t'(b);
        end
      end
      if (last) begin
        push_code(prefix, 1'b1);
        n++;
        messages_seen++;
        clear_message();
      end
      if (n == 2) double_results++;
    endfunction

    // Compare one accepted code with the oldest one owed.
    function void check_code(logic [TDATA_BITS-1:0] data, logic last);
      result_t want;
      codes_checked++;
      if (expected_codes.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected code: tdata=%0h tlast=%0b", data, last);
      end else begin
        want = expected_codes.pop_front();
        if (data !== TDATA_BITS'(want.code_word) || last !== want.final_code) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("code mismatch: expected code=%0d last=%0b, got tdata=%0h tlast=%0b",
                     want.code_word, want.final_code, data, last);
        end
      end
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_BITS-1:0]  s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_tdata;
  logic                  m_tlast;

  bit            send_idle = 1'b1;
  bit            recv_idle = 1'b1;
  int unsigned   cycles    = 0;
  lzw_scoreboard sb        = new();

  lzw_byte_encoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one byte after a random gap and hold it until the request is taken.
  task automatic send_byte(byte_t b, bit last);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.note_byte(b, last);
  endtask

  // Accept codes with random stalls and check each one.
  initial begin : code_sink
    int unsigned gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      sb.check_code(m_tdata, m_tlast);
    end
  end

  initial begin : stimulus
    int unsigned count;
    int unsigned len;
    int unsigned alpha;
    byte_t       base;
    byte_t       b;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Single-byte messages at both byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Repeated pairs: prefix grows through dictionary hits
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    // Same message again: old entries must not match after the clear
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    // Run of one byte, then a mismatch on the last byte (two codes at once)
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Alternating extremes
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // Random messages, mostly short, drawn from alphabets of several sizes
    count = 0;
    while (count < RANDOM_ITEMS) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0:       alpha = 2;
        1:       alpha = 4;
        2:       alpha = 16;
        default: alpha = 256;
      endcase
      base = byte_t'($urandom_range(0, 255));
      for (int i = 0; i < len; i++) begin
        b = base + byte_t'($urandom_range(0, alpha - 1));
        send_byte(b, i == len - 1);
      end
      count += len;
    end

    // Closing run of one byte
    send_idle = 1'b1;
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    s_tvalid <= 1'b0;

    // Drain the owed codes, then watch for strays
    while (sb.expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d messages, %0d codes checked, %0d bytes gave two codes",
             sb.bytes_seen, sb.messages_seen, sb.codes_checked, sb.double_results);
    $display("dictionary ran full: %0s, mismatches: %0d",
             sb.reached_full ? "yes" : "no", sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
sv/lzw_pkg.sv
sv/lzw_ram.sv
sv/lzw_byte_encoder_top.sv
test/tb.sv
